>>> sv/lsbr_pkg.sv
// Shared definitions for the LSB-first bit reader: opcodes, status codes
// and default sizes. No dependencies.
`default_nettype none

package lsbr_pkg;

	localparam int BUFFER_BYTES_DEF  = 256;
	localparam int MAX_RUN_BYTES_DEF = 64;

	// widest bit read and the bits per byte
	localparam int MAX_READ_BITS = 32;
	localparam int BYTE_BITS     = 8;

	// run counter holds up to 127, enough for a run of 64
	localparam int RUN_W = 7;

	typedef enum logic [2:0] {
		OP_LOAD   = 3'd0,
		OP_BITS   = 3'd1,
		OP_BYTE   = 3'd2,
		OP_HALF   = 3'd3,
		OP_WORD   = 3'd4,
		OP_RUN    = 3'd5,
		OP_SKIP   = 3'd6,
		OP_REWIND = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_UNDERFLOW = 2'd1,
		STS_TOO_LARGE = 2'd2
	} status_t;

endpackage

`default_nettype wire

>>> sv/lsbr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; used for the byte buffer of the bit reader.
`default_nettype none

module lsbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/lsb_first_bit_reader.sv
// Top level of the LSB-first bit reader: cursor, sequencer and result register.
// Depends on lsbr_pkg and lsbr_ram.
`default_nettype none

// Reads bits (LSB first), bytes, little-endian halves and words, byte runs
// and skips from a byte buffer that load items fill. A load gives no result.
// A read of n buffer bytes (bit read: the bytes the bits touch, up to five;
// byte/half/word: 1, 2 or 4) is fetched through the single read port of the
// buffer memory, one byte per cycle, and passes from the fetch state through
// the done state into the result register. A run of N bytes gives N results,
// one per byte, each read from the buffer before it is handed out. Skip,
// rewind, a zero-count read and every error give their one result in the
// cycle after the item is taken. Items are taken only when the sequencer is
// idle and the result register is free or being emptied. Errors leave the
// cursor as it was. The length register can be written at any time the
// block is idle; cfg_ready is always high.
module lsb_first_bit_reader
	import lsbr_pkg::*;
#(
	parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF,
	parameter int MAX_RUN_BYTES = MAX_RUN_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data,

	input  logic        item_valid,
	output logic        item_stall,
	input  logic [2:0]  opcode,
	input  logic [8:0]  count,
	input  logic        sign_extend,
	input  logic [7:0]  load_address,
	input  logic [7:0]  load_data,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] value,
	output logic [1:0]  status,
	output logic        last,
	output logic [8:0]  position,
	output logic [8:0]  remaining,
	output logic        has_more
);

	localparam int AW     = $clog2(BUFFER_BYTES);
	localparam int XW     = (AW > 10) ? AW : 10;
	localparam int WIN_W  = 5 * BYTE_BITS;
	localparam logic [8:0] BUF9    = 9'(BUFFER_BYTES);
	localparam logic [8:0] MAX_RUN = 9'(MAX_RUN_BYTES);
	localparam logic [8:0] MAX_BITS = 9'(MAX_READ_BITS);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_FETCH   = 5'b00010,
		S_DONE    = 5'b00100,
		S_RUN_RD  = 5'b01000,
		S_RUN_OUT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [8:0]       len_q;
	logic [8:0]       pos_q, pos_d;
	logic [2:0]       bo_q, bo_d;
	logic [2:0]       iss_q, iss_d;
	logic [2:0]       need_q, need_d;
	logic [WIN_W-1:0] win_q, win_d;
	logic [RUN_W-1:0] left_q, left_d;
	op_t              op_q, op_d;
	logic [5:0]       cnt_q, cnt_d;
	logic             sx_q, sx_d;
	logic             rd_s1, rd_d;
	logic [2:0]       rdidx_s1, rdidx_d;

	logic             result_valid_q;
	logic [31:0]      value_q;
	logic [1:0]       status_q;
	logic             last_q;
	logic [8:0]       position_q;
	logic [8:0]       remaining_q;
	logic             has_more_q;

	logic [8:0]  eff;
	logic        out_free;
	logic        accept;
	op_t         op_in;
	logic [5:0]  bits_sum_in;
	logic [2:0]  need_bits;
	logic [12:0] bits_total;
	logic        bits_over;
	logic [8:0]  fit_n;
	logic [2:0]  need_fix;
	logic        fit;
	logic        load_ok;
	logic [5:0]  bits_end;
	logic [8:0]  done_pos;
	logic [WIN_W-1:0] shifted;
	logic [WIN_W-1:0] mask;
	logic [31:0] done_val;

	logic        emit;
	logic [31:0] e_val;
	status_t     e_sts;
	logic        e_last;
	logic [8:0]  e_pos;
	logic [8:0]  e_rem;

	logic          mem_we;
	logic          mem_re;
	logic [2:0]    off;
	logic [9:0]    rsum;
	logic [XW-1:0] raddr_x;
	logic [XW-1:0] waddr_x;
	logic [7:0]    rdata;

	assign cfg_ready = 1'b1;

	// clamp the length register to the buffer size
	assign eff = (32'(len_q) < 32'(BUFFER_BYTES)) ? len_q : BUF9;

	assign out_free   = !result_valid_q || !result_stall;
	assign item_stall = !((state_q == S_IDLE) && out_free);
	assign accept     = item_valid && !item_stall;
	assign op_in      = op_t'(opcode);

	assign bits_sum_in = 6'(bo_q) + count[5:0];
	assign need_bits   = 3'((bits_sum_in + 6'd7) >> 3);
	assign bits_total  = {1'b0, pos_q, bo_q} + 13'(count);
	assign bits_over   = bits_total > {1'b0, eff, 3'b000};

	always_comb begin
		case (op_in)
			OP_BYTE: fit_n = 9'd1;
			OP_HALF: fit_n = 9'd2;
			OP_WORD: fit_n = 9'd4;
			default: fit_n = count;
		endcase
	end
	assign need_fix = fit_n[2:0];
	assign fit      = (10'(pos_q) + 10'(fit_n)) <= 10'(eff);
	assign load_ok  = 32'(load_address) < 32'(BUFFER_BYTES);

	assign bits_end = 6'(bo_q) + cnt_q;
	assign done_pos = (op_q == OP_BITS) ? pos_q + 9'(bits_end >> 3) : pos_q + 9'(need_q);
	assign shifted  = win_q >> bo_q;
	assign mask     = (WIN_W'(1) << cnt_q) - WIN_W'(1);

	always_comb begin
		case (op_q)
			OP_BITS: done_val = 32'(shifted & mask);
			OP_BYTE: done_val = {{24{sx_q & win_q[7]}}, win_q[7:0]};
			OP_HALF: done_val = {{16{sx_q & win_q[15]}}, win_q[15:0]};
			OP_WORD: done_val = win_q[31:0];
			default: done_val = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		bo_d    = bo_q;
		iss_d   = iss_q;
		need_d  = need_q;
		win_d   = win_q;
		left_d  = left_q;
		op_d    = op_q;
		cnt_d   = cnt_q;
		sx_d    = sx_q;
		rd_d    = 1'b0;
		rdidx_d = rdidx_s1;
		emit    = 1'b0;
		e_val   = '0;
		e_sts   = STS_OK;
		e_last  = 1'b1;
		e_pos   = pos_q;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		off     = '0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_d  = op_in;
					cnt_d = count[5:0];
					sx_d  = sign_extend;
					iss_d = '0;
					win_d = '0;
					case (op_in)
						OP_LOAD: begin
							mem_we = load_ok;
						end
						OP_BITS: begin
							if (count > MAX_BITS) begin
								emit  = 1'b1;
								e_sts = STS_TOO_LARGE;
							end else if (bits_over) begin
								emit  = 1'b1;
								e_sts = STS_UNDERFLOW;
							end else if (count == 9'd0) begin
								emit = 1'b1;
							end else begin
								need_d  = need_bits;
								state_d = S_FETCH;
							end
						end
						OP_BYTE, OP_HALF, OP_WORD: begin
							if (!fit) begin
								emit  = 1'b1;
								e_sts = STS_UNDERFLOW;
							end else begin
								need_d  = need_fix;
								state_d = S_FETCH;
							end
						end
						OP_RUN: begin
							if (count > MAX_RUN) begin
								emit  = 1'b1;
								e_sts = STS_TOO_LARGE;
							end else if (!fit) begin
								emit  = 1'b1;
								e_sts = STS_UNDERFLOW;
							end else if (count == 9'd0) begin
								emit = 1'b1;
							end else begin
								left_d  = RUN_W'(count);
								state_d = S_RUN_RD;
							end
						end
						OP_SKIP: begin
							emit = 1'b1;
							if (!fit) begin
								e_sts = STS_UNDERFLOW;
							end else begin
								pos_d = pos_q + count;
								e_pos = pos_d;
							end
						end
						OP_REWIND: begin
							emit  = 1'b1;
							pos_d = '0;
							bo_d  = '0;
							e_pos = '0;
						end
						default: ;
					endcase
				end
			end
			S_FETCH: begin
				// issue one byte per cycle, capture it in the cycle after
				if (iss_q < need_q) begin
					mem_re  = 1'b1;
					off     = iss_q;
					rd_d    = 1'b1;
					rdidx_d = iss_q;
					iss_d   = iss_q + 3'd1;
				end
				if (rd_s1) begin
					win_d[{rdidx_s1, 3'b000} +: 8] = rdata;
					if (rdidx_s1 == need_q - 3'd1) begin
						state_d = S_DONE;
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					emit  = 1'b1;
					e_val = done_val;
					e_pos = done_pos;
					pos_d = done_pos;
					if (op_q == OP_BITS) begin
						bo_d = bits_end[2:0];
					end
					state_d = S_IDLE;
				end
			end
			S_RUN_RD: begin
				mem_re  = 1'b1;
				state_d = S_RUN_OUT;
			end
			S_RUN_OUT: begin
				// advance the cursor one byte per transfer
				if (out_free) begin
					emit    = 1'b1;
					e_val   = {24'b0, rdata};
					e_last  = (left_q == RUN_W'(1));
					e_pos   = pos_q + 9'd1;
					pos_d   = e_pos;
					left_d  = left_q - RUN_W'(1);
					state_d = e_last ? S_IDLE : S_RUN_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign e_rem = (e_pos < eff) ? eff - e_pos : 9'd0;

	assign rsum    = {1'b0, pos_q} + 10'(off);
	assign raddr_x = XW'(rsum);
	assign waddr_x = XW'(load_address);

	lsbr_ram #(
		.WIDTH(BYTE_BITS),
		.DEPTH(BUFFER_BYTES)
	) u_buf (
		.clk  (clk),
		.we   (mem_we),
		.waddr(waddr_x[AW-1:0]),
		.wdata(load_data),
		.re   (mem_re),
		.raddr(raddr_x[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			len_q          <= '0;
			pos_q          <= '0;
			bo_q           <= '0;
			iss_q          <= '0;
			need_q         <= '0;
			left_q         <= '0;
			op_q           <= OP_LOAD;
			rd_s1          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			bo_q    <= bo_d;
			iss_q   <= iss_d;
			need_q  <= need_d;
			left_q  <= left_d;
			op_q    <= op_d;
			rd_s1   <= rd_d;
			if (cfg_valid && cfg_ready) begin
				len_q <= cfg_data;
			end
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		win_q    <= win_d;
		cnt_q    <= cnt_d;
		sx_q     <= sx_d;
		rdidx_s1 <= rdidx_d;
		if (emit) begin
			value_q     <= e_val;
			status_q    <= e_sts;
			last_q      <= e_last;
			position_q  <= e_pos;
			remaining_q <= e_rem;
			has_more_q  <= (e_pos < eff);
		end
	end

	assign result_valid = result_valid_q;
	assign value        = value_q;
	assign status       = status_q;
	assign last         = last_q;
	assign position     = position_q;
	assign remaining    = remaining_q;
	assign has_more     = has_more_q;

endmodule

`default_nettype wire
